### rtl/smtk_pkg.sv
package smtk_pkg;

    localparam int ModuleCountDef = 4;
    localparam int CordicStepsDef = 16;
    localparam int TabLen = 24;

    localparam int PiQ12 = 12868;
    localparam int HalfPiQ12 = 6434;
    localparam int HalfPiQ24 = 26353589;
    localparam int HoldLimitQ12 = 1229;
    localparam int InvGainQ30 = 652032874;

    // datapath width for CORDIC vectors: 8 fraction bits plus headroom
    localparam int VW = 44;
    localparam int ZW = 28;

    typedef logic signed [VW-1:0] vec_t;
    typedef logic signed [ZW-1:0] ang_t;

    localparam logic [3:0] OP_ROT = 4'd0;
    localparam logic [3:0] OP_VEC = 4'd1;

    function automatic ang_t atan_q24(input logic [4:0] i);
        ang_t r;
        r = '0;
        case (i)
            5'd0:  r = ZW'(13176795);
            5'd1:  r = ZW'(7778716);
            5'd2:  r = ZW'(4110060);
            5'd3:  r = ZW'(2086331);
            5'd4:  r = ZW'(1047214);
            5'd5:  r = ZW'(524117);
            5'd6:  r = ZW'(262123);
            5'd7:  r = ZW'(131069);
            5'd8:  r = ZW'(65536);
            5'd9:  r = ZW'(32768);
            5'd10: r = ZW'(16384);
            5'd11: r = ZW'(8192);
            5'd12: r = ZW'(4096);
            5'd13: r = ZW'(2048);
            5'd14: r = ZW'(1024);
            5'd15: r = ZW'(512);
            5'd16: r = ZW'(256);
            5'd17: r = ZW'(128);
            5'd18: r = ZW'(64);
            5'd19: r = ZW'(32);
            5'd20: r = ZW'(16);
            5'd21: r = ZW'(8);
            5'd22: r = ZW'(4);
            5'd23: r = ZW'(2);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### rtl/smtk_cordic.sv
module smtk_cordic
    import smtk_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDef
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       vec_mode,
    input  vec_t       x_in,
    input  vec_t       y_in,
    input  ang_t       z_in,
    output logic       done,
    output vec_t       x_out,
    output vec_t       y_out,
    output ang_t       z_out
);

    localparam int NSTEP = (CORDIC_STEPS < TabLen) ? CORDIC_STEPS : TabLen;

    vec_t x_reg, y_reg;
    ang_t z_reg;
    logic [4:0] i_reg;
    logic busy_reg, mode_reg, done_reg;
    logic dir;
    vec_t sx, sy;

    assign sx = x_reg >>> i_reg;
    assign sy = y_reg >>> i_reg;
    assign dir = mode_reg ? (y_reg > 0) : (z_reg < 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (i_reg == 5'(NSTEP - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                i_reg <= i_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
            mode_reg <= vec_mode;
        end
        else if (busy_reg)
        begin
            if (dir)
            begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + atan_q24(i_reg);
            end
            else
            begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - atan_q24(i_reg);
            end
        end
    end

    assign done = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

### rtl/swerve_module_target_kinematics.sv
// Swerve drive inverse kinematics for four modules. One transfer in produces one
// result transfer of four (speed, angle) pairs. A single CORDIC unit, one
// micro-rotation per cycle, serves the heading rotation and the four module
// vectorings. in_ready stays low until the result transfer has been taken, so a
// new item is not accepted while the previous one is in progress or waiting.
// Offsets are written through the configuration port while idle; the 3-bit
// index covers all eight offset entries.
module swerve_module_target_kinematics
    import smtk_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDef
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] target_vx,
    input  logic signed [15:0] target_vy,
    input  logic signed [15:0] target_rate,
    input  logic signed [14:0] heading,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        speed0,
    output logic signed [14:0] angle0,
    output logic [15:0]        speed1,
    output logic signed [14:0] angle1,
    output logic [15:0]        speed2,
    output logic signed [14:0] angle2,
    output logic [15:0]        speed3,
    output logic signed [14:0] angle3
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROT  = 3'd1;
    localparam logic [2:0] S_GX   = 3'd2;
    localparam logic [2:0] S_GY   = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_VEC  = 3'd5;
    localparam logic [2:0] S_SPD  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic signed [15:0] off_reg [8];
    logic [2:0] state_reg;
    logic hold_active_reg;
    logic signed [15:0] hold_heading_reg;
    logic signed [17:0] rate_reg;
    vec_t rx_reg, ry_reg;
    ang_t ang_reg;
    logic [1:0] k_reg;
    logic [15:0] spd_reg [4];
    logic signed [14:0] angq_reg [4];
    logic signed [63:0] prod_reg;

    logic c_start, c_mode, c_done;
    vec_t c_xi, c_yi, c_xo, c_yo;
    ang_t c_zi, c_zo;

    smtk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(c_start), .vec_mode(c_mode),
        .x_in(c_xi), .y_in(c_yi), .z_in(c_zi), .done(c_done),
        .x_out(c_xo), .y_out(c_yo), .z_out(c_zo)
    );

    assign cfg_ready = (state_reg == S_IDLE) && !out_valid;
    assign in_ready = (state_reg == S_IDLE) && !out_valid;

    // hold logic on input
    logic signed [16:0] herr_raw, herr;
    logic signed [16:0] hh_eff;
    logic signed [17:0] corr;
    logic signed [17:0] rate_new;
    logic hold_new;
    logic signed [16:0] a_raw, a_w;
    vec_t rx0, ry0;
    ang_t a_q;

    always_comb
    begin
        hh_eff = hold_active_reg ? 17'(hold_heading_reg) : 17'(heading);
        herr_raw = hh_eff - 17'(heading);
        herr = herr_raw;
        if (herr_raw > 17'sd12868)
            herr = herr_raw - 17'sd25736;
        else if (herr_raw < -17'sd12868)
            herr = herr_raw + 17'sd25736;
        corr = 18'((20'sd7 * 20'(herr) + 20'sd16) >>> 5);
        rate_new = 18'(target_rate);
        hold_new = 1'b0;
        if (target_rate == 16'sd0)
        begin
            if (herr < 17'sd1229 && herr > -17'sd1229)
            begin
                rate_new = corr;
                hold_new = 1'b1;
            end
        end
        a_raw = -17'(heading);
        a_w = a_raw;
        if (a_raw > 17'sd12868)
            a_w = a_raw - 17'sd25736;
        else if (a_raw < -17'sd12868)
            a_w = a_raw + 17'sd25736;
        rx0 = VW'(target_vx) <<< 8;
        ry0 = VW'(target_vy) <<< 8;
        if (a_w > 17'sd6434)
        begin
            rx0 = -(VW'(target_vy) <<< 8);
            ry0 = VW'(target_vx) <<< 8;
            a_w = a_w - 17'sd6434;
        end
        else if (a_w < -17'sd6434)
        begin
            rx0 = VW'(target_vy) <<< 8;
            ry0 = -(VW'(target_vx) <<< 8);
            a_w = a_w + 17'sd6434;
        end
        a_q = ZW'(a_w) <<< 12;
    end

    // module vector
    logic signed [15:0] mdx, mdy;
    vec_t mx, my;
    assign mdx = off_reg[{k_reg, 1'b0}];
    assign mdy = off_reg[{k_reg, 1'b1}];
    assign mx = rx_reg - VW'(mdy) * VW'(rate_reg);
    assign my = ry_reg + VW'(mdx) * VW'(rate_reg);

    vec_t vx0, vy0;
    ang_t vz0;
    always_comb
    begin
        vx0 = mx;
        vy0 = my;
        vz0 = '0;
        if (mx < 0)
        begin
            if (my >= 0)
            begin
                vx0 = my; vy0 = -mx; vz0 = ZW'(HalfPiQ24);
            end
            else
            begin
                vx0 = -my; vy0 = mx; vz0 = -ZW'(HalfPiQ24);
            end
        end
    end

    always_comb
    begin
        c_start = 1'b0;
        c_mode = 1'b0;
        c_xi = rx0;
        c_yi = ry0;
        c_zi = a_q;
        if (state_reg == S_IDLE)
            c_start = in_valid && in_ready;
        else if (state_reg == S_MOD)
        begin
            c_start = 1'b1;
            c_mode = 1'b1;
            c_xi = vx0;
            c_yi = vy0;
            c_zi = vz0;
        end
    end

    // shared gain compensation; CORDIC outputs stay within 34 bits
    logic signed [33:0] gain_op;
    logic signed [63:0] gain_prod;
    assign gain_op = (state_reg == S_GX) ? 34'(c_yo) : 34'(c_xo);
    assign gain_prod = 64'(gain_op) * 64'(InvGainQ30);

    // speed rounding from product, angle rounding and clamping
    logic signed [63:0] spd_full;
    logic signed [14:0] angq_c;
    logic signed [ZW-1:0] ang_r;
    logic [15:0] spd_c;
    always_comb
    begin
        spd_full = (prod_reg + (64'sd1 <<< 37)) >>> 38;
        if (spd_full < 0)
            spd_c = '0;
        else if (spd_full > 64'sd65535)
            spd_c = 16'hFFFF;
        else
            spd_c = spd_full[15:0];
        ang_r = (ang_reg + ZW'(2048)) >>> 12;
        if (ang_r > ZW'(PiQ12))
            angq_c = 15'(PiQ12);
        else if (ang_r < -ZW'(PiQ12))
            angq_c = -15'(PiQ12);
        else
            angq_c = ang_r[14:0];
        if (spd_c == 16'd0)
            angq_c = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hold_active_reg <= 1'b0;
            hold_heading_reg <= '0;
            out_valid <= 1'b0;
            for (int j = 0; j < 8; j++)
                off_reg[j] <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (cfg_valid && cfg_ready)
                off_reg[cfg_index] <= cfg_data;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        if (target_rate == 16'sd0 && !hold_active_reg)
                            hold_heading_reg <= 16'(heading);
                        hold_active_reg <= hold_new;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT:
                    if (c_done)
                        state_reg <= S_GX;
                S_GX:   state_reg <= S_GY;
                S_GY:   state_reg <= S_MOD;
                S_MOD:  state_reg <= S_VEC;
                S_VEC:
                    if (c_done)
                        state_reg <= S_SPD;
                S_SPD:  state_reg <= S_OUT;
                S_OUT:
                begin
                    if (k_reg == 2'd3)
                    begin
                        state_reg <= S_IDLE;
                        out_valid <= 1'b1;
                    end
                    else
                        state_reg <= S_MOD;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                rate_reg <= rate_new;
                k_reg <= '0;
            end
            S_ROT:
                if (c_done)
                    prod_reg <= gain_prod;
            S_GX:
            begin
                rx_reg <= VW'(prod_reg >>> 30);
                prod_reg <= gain_prod;
            end
            S_GY:   ry_reg <= VW'(prod_reg >>> 30);
            S_VEC:
                if (c_done)
                begin
                    prod_reg <= gain_prod;
                    ang_reg <= c_zo;
                end
            S_SPD:
            begin
                spd_reg[k_reg] <= spd_c;
                angq_reg[k_reg] <= angq_c;
            end
            S_OUT:  k_reg <= k_reg + 2'd1;
            default: ;
        endcase
    end

    assign speed0 = spd_reg[0];
    assign angle0 = angq_reg[0];
    assign speed1 = spd_reg[1];
    assign angle1 = angq_reg[1];
    assign speed2 = spd_reg[2];
    assign angle2 = angq_reg[2];
    assign speed3 = spd_reg[3];
    assign angle3 = angq_reg[3];

endmodule

### tb/sv/tb_swerve_module_target_kinematics_checker.sv
`timescale 1ns / 1ps

module tb_swerve_module_target_kinematics_checker
    import smtk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] target_vx,
    input  logic signed [15:0] target_vy,
    input  logic signed [15:0] target_rate,
    input  logic signed [14:0] heading,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [15:0]        speed0,
    input  logic signed [14:0] angle0,
    input  logic [15:0]        speed1,
    input  logic signed [14:0] angle1,
    input  logic [15:0]        speed2,
    input  logic signed [14:0] angle2,
    input  logic [15:0]        speed3,
    input  logic signed [14:0] angle3,
    output int                 mismatch_count,
    output int                 pending_count
);

    localparam int Steps = (CordicStepsDef < TabLen) ? CordicStepsDef : TabLen;

    typedef struct packed {
        logic [3:0][15:0] spd;
        logic [3:0][14:0] ang;
    } wheel_cmd_t;

    wheel_cmd_t        cmd_queue[$];
    logic signed [15:0] offset_reg[8];
    logic               holding;
    longint             held_heading;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint wrap_pi(longint a);
        if (a > PiQ12)
            return a - 2 * PiQ12;
        else if (a < -PiQ12)
            return a + 2 * PiQ12;
        return a;
    endfunction

    function automatic longint atan_entry(int i);
        return longint'(atan_q24(5'(i)));
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic wheel_cmd_t solve_wheels(longint vx, longint vy, longint trate,
                                                longint h);
        wheel_cmd_t r;
        longint rate, e, rx, ry, a, t, z, da, db, dx, dy, mx, my, x, y, spd, angq;
        rate = trate;
        if (trate == 0) begin
            if (!holding) begin
                holding = 1'b1;
                held_heading = h;
            end
            e = wrap_pi(held_heading - h);
            if (e < HoldLimitQ12 && e > -HoldLimitQ12)
                rate = shr_floor(7 * e + 16, 5);
            else
                holding = 1'b0;
        end else begin
            holding = 1'b0;
        end
        rx = vx * 256;
        ry = vy * 256;
        a = wrap_pi(-h);
        if (a > HalfPiQ12) begin
            t = rx; rx = -ry; ry = t; a -= HalfPiQ12;
        end else if (a < -HalfPiQ12) begin
            t = rx; rx = ry; ry = -t; a += HalfPiQ12;
        end
        z = a * 4096;
        for (int i = 0; i < Steps; i++) begin
            da = shr_floor(ry, i);
            db = shr_floor(rx, i);
            if (z >= 0) begin
                rx -= da; ry += db; z -= atan_entry(i);
            end else begin
                rx += da; ry -= db; z += atan_entry(i);
            end
        end
        rx = shr_floor(rx * InvGainQ30, 30);
        ry = shr_floor(ry * InvGainQ30, 30);
        for (int k = 0; k < 4; k++) begin
            dx = offset_reg[2 * k];
            dy = offset_reg[2 * k + 1];
            x = rx - dy * rate;
            y = ry + dx * rate;
            z = 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = HalfPiQ24;
                end else begin
                    x = -y; y = t; z = -HalfPiQ24;
                end
            end
            for (int i = 0; i < Steps; i++) begin
                mx = shr_floor(y, i);
                my = shr_floor(x, i);
                if (y > 0) begin
                    x += mx; y -= my; z += atan_entry(i);
                end else begin
                    x -= mx; y += my; z -= atan_entry(i);
                end
            end
            spd = shr_floor(x * InvGainQ30 + (longint'(1) << 37), 38);
            if (spd < 0) spd = 0;
            if (spd > 65535) spd = 65535;
            if (spd == 0) begin
                angq = 0;
            end else begin
                angq = shr_floor(z + 2048, 12);
                if (angq > PiQ12) angq = PiQ12;
                if (angq < -PiQ12) angq = -PiQ12;
            end
            r.spd[k] = 16'(spd);
            r.ang[k] = 15'(angq);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wheel_cmd_t want;
        logic [3:0][15:0] got_spd;
        logic [3:0][14:0] got_ang;
        if (!rst_n) begin
            for (int i = 0; i < 8; i++)
                offset_reg[i] = '0;
            holding = 1'b0;
            held_heading = 0;
            mismatch_count = 0;
            pending_count = 0;
            cmd_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                offset_reg[cfg_index] = cfg_data;
            if (in_valid && in_ready)
                cmd_queue.push_back(solve_wheels(target_vx, target_vy, target_rate,
                                                 heading));
            if (out_valid && out_ready) begin
                got_spd = {speed3, speed2, speed1, speed0};
                got_ang = {angle3, angle2, angle1, angle0};
                if (cmd_queue.size() == 0) begin
                    report_mismatch("unexpected result transfer", 1, 0);
                end else begin
                    want = cmd_queue.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (got_spd[k] !== want.spd[k])
                            report_mismatch($sformatf("speed%0d", k), got_spd[k],
                                            want.spd[k]);
                        if (got_ang[k] !== want.ang[k])
                            report_mismatch($sformatf("angle%0d", k),
                                            $signed(got_ang[k]), $signed(want.ang[k]));
                    end
                end
            end
            pending_count = cmd_queue.size();
        end
    end

endmodule

### tb/sv/tb_swerve_module_target_kinematics.sv
`timescale 1ns / 1ps

module tb_swerve_module_target_kinematics;
    import smtk_pkg::*;

    localparam longint CycleLimit = 2000000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] target_vx;
    logic signed [15:0] target_vy;
    logic signed [15:0] target_rate;
    logic signed [14:0] heading;
    logic               out_valid;
    logic               out_ready;
    logic [15:0]        speed0, speed1, speed2, speed3;
    logic signed [14:0] angle0, angle1, angle2, angle3;
    int                 mismatch_count;
    int                 pending_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    longint             cycle_count;

    swerve_module_target_kinematics dut (.*);
    tb_swerve_module_target_kinematics_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic write_offset(input logic [2:0] idx, input logic [15:0] value);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic send_command(input logic [15:0] vx, input logic [15:0] vy,
                                input logic [15:0] rate, input logic [14:0] hd);
        cfg_valid <= 1'b0;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid    <= 1'b1;
        target_vx   <= vx;
        target_vy   <= vy;
        target_rate <= rate;
        heading     <= hd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_offset(int mode);
        case (mode)
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($signed($urandom_range(200)) - 100);
        endcase
    endfunction

    task automatic set_offsets(int mode);
        for (int i = 0; i < 8; i++)
            write_offset(3'(i), (mode == 4 && i[0]) ? 16'h8000 : pick_offset(mode));
    endtask

    task automatic random_run(int count);
        logic [14:0] hd;
        logic [15:0] vx, vy;
        for (int n = 0; n < count; n++) begin
            hd = 15'($signed($urandom_range(25736)) - 12868);
            if ($urandom_range(9) == 0)
                hd = 15'($urandom);
            vx = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(1024)) - 512);
            vy = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(1024)) - 512);
            case ($urandom_range(3))
                0: send_command(vx, vy, 16'($urandom), hd);
                1: send_command(vx, vy, 16'($signed($urandom_range(512)) - 256), hd);
                default:
                begin
                    // hold sequence: small heading drift, occasionally a jump
                    send_command(vx, vy, '0, hd);
                    for (int j = $urandom_range(6); j > 0; j--) begin
                        if ($urandom_range(7) == 0)
                            hd = 15'($urandom);
                        else
                            hd = hd + 15'($signed($urandom_range(800)) - 400);
                        send_command(16'($urandom), 16'($urandom), '0, hd);
                        n++;
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        target_vx   = '0;
        target_vy   = '0;
        target_rate = '0;
        heading     = '0;
        out_ready   = 1'b0;
        cycle_count = 0;
        send_idle_pct = 16;
        recv_idle_pct = 71;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(16'h0000, 16'h0000, 16'h0000, 15'd0);
        write_offset(3'd7, 16'h0100);
        set_offsets(3);
        send_command(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'd12868);
        send_command(16'h8000, 16'h8000, 16'h8000, -15'sd12868);
        send_command(16'h7FFF, 16'h8000, 16'h0001, 15'h3FFF);
        send_command(16'h8000, 16'h7FFF, 16'hFFFF, 15'h4000);
        send_command(16'h0100, 16'h0000, 16'h0000, 15'd0);
        send_command(16'h0100, 16'h0000, 16'h0000, 15'd1228);
        send_command(16'h0100, 16'h0000, 16'h0000, -15'sd1228);
        send_command(16'h0100, 16'h0000, 16'h0000, 15'd1229);
        send_command(16'h0000, 16'h0100, 16'h0000, 15'd12800);
        send_command(16'h0000, 16'h0100, 16'h0000, -15'sd12800);
        send_command(16'h0000, 16'h0100, 16'h0000, 15'd7000);
        send_command(16'h0000, 16'h0000, 16'h0005, 15'd0);
        send_command(16'hFF00, 16'h0000, 16'h0000, 15'd6434);
        send_command(16'h0001, 16'h0000, 16'h0000, 15'd0);
        send_command(16'h5555, 16'hAAAA, 16'h5555, 15'h2AAA);
        send_command(16'hAAAA, 16'h5555, 16'hAAAA, 15'h5555);
        drain_results();

        set_offsets(0);
        random_run(150);
        drain_results();
        set_offsets(1);
        random_run(150);
        drain_results();
        set_offsets(4);
        random_run(100);
        drain_results();
        set_offsets(2);
        random_run(100);
        drain_results();

        send_idle_pct = 71;
        recv_idle_pct = 16;
        set_offsets(3);
        random_run(500);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_offsets(3);
        random_run(500);
        drain_results();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/smtk_pkg.sv
rtl/smtk_cordic.sv
rtl/swerve_module_target_kinematics.sv
tb/sv/tb_swerve_module_target_kinematics_checker.sv
tb/sv/tb_swerve_module_target_kinematics.sv
